### hdl/bff_pkg.sv
// bff_pkg: shared types, constants and functions for the FNV-1a bloom filter.
// Used by bff_ram and bloom_filter_fnv1a_unit. No dependencies.
package bff_pkg;

  localparam logic [63:0] FNV_START     = 64'hcbf2_9ce4_8422_2325;
  // FNV prime 0x100000001b3 = 2^40 + 0x1b3
  localparam int          FNV_HI_SHIFT  = 40;
  localparam logic [8:0]  FNV_MULT_LO   = 9'h1b3;
  localparam int          HASH_STEPS    = 8;
  localparam int          STEP_W        = 3;

  // action field codes
  localparam logic        ACT_CHECK     = 1'b0;
  localparam logic        ACT_ADD       = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_MOD2,
    ST_READ,
    ST_USE
  } bff_state_t;

  // one FNV-1a round: xor in a byte, multiply by the prime (mod 2^64)
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    logic [63:0] lo;
    x  = h ^ {56'd0, b};
    lo = x * {55'd0, FNV_MULT_LO};
    return (x << FNV_HI_SHIFT) + lo;
  endfunction

  // address width of a memory of the given depth, at least one bit
  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### hdl/bloom_filter_fnv1a_unit.sv
// bloom_filter_fnv1a_unit: bloom filter over 64-bit keys with FNV-1a double hashing.
// Depends on bff_pkg and bff_ram.
//
// Each input item either adds a key (action = 1, no result) or checks it
// (action = 0, one result item: maybe_present). h1 is 64-bit FNV-1a over the
// key bytes, low byte first; h2 is FNV-1a over the bytes of h1. Probe i hits
// bit (h1 + i*h2) mod FILTER_BITS of a byte-wide bit store, with the 64-bit
// sum wrapping. Items are handled one at a time; after an item is accepted
// in the idle state, the unit runs eight FNV rounds for h1, eight for h2
// (h1 mod FILTER_BITS is reduced one byte per cycle alongside), then reduces
// h2 mod FILTER_BITS a byte at a time, then takes a read and a use step per
// probe on the single RAM port pair before it is idle again. The FNV round,
// one byte a cycle, is the long pole. Probe positions after the first are
// stepped modulo FILTER_BITS by adding h2 mod FILTER_BITS and, on 64-bit
// wrap, taking off 2^64 mod FILTER_BITS, so no wide division is ever done.
// After reset the bit store, (FILTER_BITS+7)/8 bytes (125 at the defaults),
// is swept to zero one byte per cycle; in_stall stays high until the sweep
// ends. A finished check result waits in an output register; a new item is
// taken meanwhile, and only the final probe of a later check waits while
// that register is still held by out_stall.
module bloom_filter_fnv1a_unit
  import bff_pkg::*;
#(
  parameter int FILTER_BITS = 1000,
  parameter int PROBE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_maybe_present
);

  localparam int DEPTH = (FILTER_BITS + 7) / 8;
  localparam int AW    = addr_width(DEPTH);
  localparam int PW    = $clog2(FILTER_BITS);       // probe position width
  localparam int XW    = PW + AW;
  localparam int PCW   = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;

  localparam logic [PW:0]   NB        = (PW + 1)'(FILTER_BITS);
  localparam logic [64:0]   TWO_64    = 65'h1_0000_0000_0000_0000;
  localparam logic [64:0]   WRAP_FULL = TWO_64 % 65'(FILTER_BITS);
  localparam logic [PW:0]   WRAP_MOD  = WRAP_FULL[PW:0];   // 2^64 mod N
  localparam logic [PW:0]   WRAP_ADD  = NB - WRAP_MOD;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [PCW-1:0] LAST_PROBE = PCW'(PROBE_COUNT - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HASH_STEPS - 1);

  bff_state_t state_r, state_nxt;

  logic [AW-1:0]     clr_cnt_r;
  logic [STEP_W-1:0] step_r;
  logic [PCW-1:0]    probe_r;
  logic              act_r;
  logic              all_set_r;
  logic [63:0]       src_r;        // bytes still to hash
  logic [63:0]       h_r;          // running hash, h2 once hashing is done
  logic [63:0]       acc_r;        // h1 + i*h2, wrapping
  logic [63:0]       mod_val_r;    // bytes still to reduce, high byte first
  logic [PW-1:0]     mod_rem_r;
  logic [PW-1:0]     r_r;          // current probe position
  logic [PW-1:0]     d_r;          // h2 mod N
  logic              out_valid_r;
  logic              out_mp_r;

  logic [63:0]       h_nxt;
  logic [PW-1:0]     mod_rem_nxt;
  logic [PW-1:0]     r_adv;
  logic [63:0]       acc_adv;
  logic              last_step;
  logic              last_probe;
  logic              out_busy;
  logic              hold_use;
  logic              probe_bit;
  logic              accept;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     byte_addr;
  logic [7:0]        ram_rd_data;
  logic [XW-1:0]     r_ext;

  // ---------------------------------------------------------------- datapath helpers
  assign h_nxt = fnv_step(h_r, src_r[7:0]);

  // rem = (rem * 256 + byte) mod N, one conditional subtract per bit
  always_comb begin
    logic [PW:0]   t;
    logic [PW-1:0] rem;
    rem = mod_rem_r;
    for (int k = 7; k >= 0; k--) begin
      t = {rem, mod_val_r[56 + k]};
      if (t >= NB) begin
        t = t - NB;
      end
      rem = t[PW-1:0];
    end
    mod_rem_nxt = rem;
  end

  // next probe position: (r + d) mod N, corrected by 2^64 mod N on wrap
  always_comb begin
    logic [64:0] sum;
    logic [PW:0] s;
    sum     = {1'b0, acc_r} + {1'b0, h_r};
    acc_adv = sum[63:0];
    s       = {1'b0, r_r} + {1'b0, d_r};
    if (s >= NB) begin
      s = s - NB;
    end
    if (sum[64]) begin
      if (s >= WRAP_MOD) begin
        s = s - WRAP_MOD;
      end else begin
        s = s + WRAP_ADD;
      end
    end
    r_adv = s[PW-1:0];
  end

  assign r_ext      = XW'(r_r);
  assign byte_addr  = r_ext[AW+2:3];
  assign probe_bit  = ram_rd_data[r_r[2:0]];
  assign last_step  = (step_r == LAST_STEP);
  assign last_probe = (probe_r == LAST_PROBE);
  assign out_busy   = out_valid_r && out_stall;
  // a check's result cannot land while the output register is still held
  assign hold_use   = last_probe && !act_r && out_busy;
  assign accept     = in_valid && !in_stall;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_HASH1;
      ST_HASH1: if (last_step) state_nxt = ST_HASH2;
      ST_HASH2: if (last_step) state_nxt = ST_MOD2;
      ST_MOD2:  if (last_step) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_USE;
      ST_USE: begin
        if (!hold_use) begin
          state_nxt = last_probe ? ST_IDLE : ST_READ;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall    = 1'b1;
    ram_wr_en   = 1'b0;
    ram_wr_addr = byte_addr;
    ram_wr_data = ram_rd_data | (8'd1 << r_r[2:0]);
    ram_rd_en   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = 8'd0;
      end
      ST_IDLE:  in_stall  = 1'b0;
      ST_READ:  ram_rd_en = 1'b1;
      ST_USE:   ram_wr_en = act_r;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_HASH1 || state_r == ST_HASH2 || state_r == ST_MOD2) begin
        step_r <= step_r + 1'b1;
      end
      if (accept) begin
        probe_r <= '0;
      end else if (state_r == ST_USE && !hold_use && !last_probe) begin
        probe_r <= probe_r + 1'b1;
      end
      if (state_r == ST_USE && !hold_use && last_probe && !act_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_r     <= in_action;
          src_r     <= in_key;
          h_r       <= FNV_START;
          all_set_r <= 1'b1;
        end
      end
      ST_HASH1: begin
        if (last_step) begin
          src_r     <= h_nxt;
          acc_r     <= h_nxt;
          mod_val_r <= h_nxt;
          mod_rem_r <= '0;
          h_r       <= FNV_START;
        end else begin
          src_r <= src_r >> 8;
          h_r   <= h_nxt;
        end
      end
      ST_HASH2: begin
        h_r   <= h_nxt;
        src_r <= src_r >> 8;
        if (last_step) begin
          r_r       <= mod_rem_nxt;
          mod_rem_r <= '0;
          mod_val_r <= h_nxt;
        end else begin
          mod_rem_r <= mod_rem_nxt;
          mod_val_r <= mod_val_r << 8;
        end
      end
      ST_MOD2: begin
        mod_rem_r <= mod_rem_nxt;
        mod_val_r <= mod_val_r << 8;
        if (last_step) begin
          d_r <= mod_rem_nxt;
        end
      end
      ST_USE: begin
        if (!act_r) begin
          all_set_r <= all_set_r & probe_bit;
        end
        if (!hold_use) begin
          if (last_probe) begin
            out_mp_r <= act_r ? out_mp_r : (all_set_r & probe_bit);
          end else begin
            r_r   <= r_adv;
            acc_r <= acc_adv;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

  bff_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (byte_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------- assertions
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ({1'b0, r_r} < NB))
    else $error("probe position not below filter size");

  a_no_write_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && state_r != ST_CLEAR) |-> act_r)
    else $error("bit store written during a check");

  a_result_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_USE && !act_r && last_probe))
    else $error("result raised without a finished check");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == ST_USE && !act_r && last_probe)
      |=> (state_r == ST_USE))
    else $error("check finished while result register was held");

endmodule

### hdl/bff_ram.sv
// bff_ram: generic single-clock RAM, one write port, one read port with registered data.
// Depends on bff_pkg for the address width rule.
module bff_ram
  import bff_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 125,
  localparam int AW = addr_width(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
